// File: hdl/nph_pkg.sv
// Shared types, constants and the arctangent table for the nearest point heading block.
// Used by nph_ctrl, nph_datapath and nearest_point_heading; depends on nothing.
`default_nettype none

package nph_pkg;

  // Coordinate and result widths.
  localparam int COORD_W   = 12;
  localparam int DIFF_W    = COORD_W + 1;
  localparam int SQ_W      = 2 * COORD_W;
  localparam int DIST_W    = 2 * COORD_W + 1;
  localparam int HEAD_W    = 16;
  localparam int IN_DATA_W = 24;
  localparam int OUT_DATA_W = 40;
  localparam int OUT_USER_W = 2;
  localparam int CFG_IDX_W = 1;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_SELF_X = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SELF_Y = 1'b1;

  // CORDIC sizing. X and Y carry the difference scaled by 2^20 plus the gain growth;
  // Z carries the angle in Q30 with room for the starting offset of plus or minus pi.
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int TAB_LEN   = 24;
  localparam int TAB_IDX_W = 5;
  localparam int ANG_TAB_W = 30;
  localparam int XY_W      = 36;
  localparam int XY_FRAC   = 20;
  localparam int Z_W       = 34;

  localparam logic signed [Z_W-1:0] PI_Q30 = 34'sd3373259426;
  localparam logic signed [Z_W:0] ROUND_HALF = 35'sd65536;
  localparam int HEAD_SHIFT = 17;
  localparam int HQ_W = Z_W + 1 - HEAD_SHIFT;
  localparam logic signed [HQ_W-1:0] HEAD_MAX = 18'sd25736;
  localparam logic signed [HQ_W-1:0] HEAD_MIN = -18'sd25736;

  typedef enum logic [2:0] {
    ST_SCAN,
    ST_DRAIN,
    ST_LOAD,
    ST_ITER,
    ST_FINAL
  } ctl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic                 accept;
    logic                 load_head;
    logic                 iter;
    logic [TAB_IDX_W-1:0] step;
    logic                 out_load;
  } nph_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
  } nph_stat_t;

  // atan(2^-i) in Q30.
  function automatic logic [ANG_TAB_W-1:0] atan_q30(input logic [TAB_IDX_W-1:0] i);
    logic [ANG_TAB_W-1:0] v;
    case (i)
      5'd0:  v = 30'd843314857;
      5'd1:  v = 30'd497837829;
      5'd2:  v = 30'd263043837;
      5'd3:  v = 30'd133525159;
      5'd4:  v = 30'd67021687;
      5'd5:  v = 30'd33543516;
      5'd6:  v = 30'd16775851;
      5'd7:  v = 30'd8388437;
      5'd8:  v = 30'd4194283;
      5'd9:  v = 30'd2097149;
      5'd10: v = 30'd1048576;
      5'd11: v = 30'd524288;
      5'd12: v = 30'd262144;
      5'd13: v = 30'd131072;
      5'd14: v = 30'd65536;
      5'd15: v = 30'd32768;
      5'd16: v = 30'd16384;
      5'd17: v = 30'd8192;
      5'd18: v = 30'd4096;
      5'd19: v = 30'd2048;
      5'd20: v = 30'd1024;
      5'd21: v = 30'd512;
      5'd22: v = 30'd256;
      5'd23: v = 30'd128;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// File: hdl/nearest_point_heading.sv
// Top level of the nearest point heading block: ports, controller and datapath.
// Depends on nph_pkg, nph_ctrl and nph_datapath.
//
//   Channel  Direction  Handshake                Contents
//   s_*      in         s_tvalid / s_tready      one population point, s_tlast on the final one
//   m_*      out        m_tvalid / m_tready      one result per population
//   cfg_*    in         cfg_we, no wait          own position, index 0 = x, index 1 = y
//
// Points stream in at one request per clock cycle through a two-stage pipeline
// (squares, then sum and compare). After the request flagged with s_tlast the input stalls
// while the distance pipeline drains, the CORDIC is loaded, the shared micro-rotation unit
// runs through its steps and the output register is filled.
// A waiting result in the output register does not block the next population unless a
// second result is ready before the first is taken. Reset is synchronous and active high;
// it clears the position registers, the search state and the output valid flag.
`default_nettype none

module nearest_point_heading
  import nph_pkg::*;
#(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // Point requests.
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [IN_DATA_W-1:0]  s_tdata,   // other_x [11:0], other_y [23:12]
  input  wire logic                  s_tlast,   // last_point
  // Results.
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [OUT_DATA_W-1:0]      m_tdata,   // near_x [11:0], near_y [23:12], heading [39:24]
  output logic [OUT_USER_W-1:0]      m_tuser,   // found [0], turn [1]
  // Configuration writes.
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [COORD_W-1:0]    cfg_data
);

  nph_cmd_t                 cmd;
  nph_stat_t                stat;
  logic                     out_found, out_turn;
  logic [COORD_W-1:0]       out_x, out_y;
  logic signed [HEAD_W-1:0] out_heading;

  nph_ctrl #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tlast  (s_tlast),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  nph_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .other_x     (s_tdata[COORD_W-1:0]),
    .other_y     (s_tdata[2*COORD_W-1:COORD_W]),
    .cmd         (cmd),
    .stat        (stat),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_found   (out_found),
    .out_x       (out_x),
    .out_y       (out_y),
    .out_turn    (out_turn),
    .out_heading (out_heading)
  );

  // The field widths fill the data word exactly, so no padding is needed.
  assign m_tdata = {out_heading, out_y, out_x};
  assign m_tuser = {out_turn, out_found};

endmodule

`default_nettype wire

// File: hdl/nph_ctrl.sv
// Sequencing state machine for the nearest point heading block.
// Depends on nph_pkg; drives nph_datapath through nph_cmd_t.
`default_nettype none

module nph_ctrl
  import nph_pkg::*;
#(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      s_tvalid,
  input  wire logic      s_tlast,
  output logic           s_tready,
  input  wire nph_stat_t stat,
  output nph_cmd_t       cmd
);

  localparam int STEP_W = $clog2(CORDIC_STEPS);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CORDIC_STEPS - 1);

  ctl_state_t        state, state_next;
  logic [STEP_W-1:0] step, step_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_SCAN;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  always_comb begin
    state_next    = state;
    step_next     = step;
    s_tready      = 1'b0;
    cmd           = '0;
    cmd.step      = TAB_IDX_W'(step);
    case (state)
      ST_SCAN: begin
        s_tready   = 1'b1;
        cmd.accept = s_tvalid;
        if (s_tvalid && s_tlast) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // The last request is folded into the running best this cycle.
        state_next = ST_LOAD;
      end
      ST_LOAD: begin
        cmd.load_head = 1'b1;
        step_next     = '0;
        state_next    = ST_ITER;
      end
      ST_ITER: begin
        cmd.iter = 1'b1;
        if (step == LAST_STEP) begin
          state_next = ST_FINAL;
        end else begin
          step_next = step + 1'b1;
        end
      end
      ST_FINAL: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_SCAN;
        end
      end
      default: begin
        state_next = ST_SCAN;
      end
    endcase
  end

  a_last_drains: assert property (@(posedge clk) disable iff (rst)
    (cmd.accept && s_tlast) |=> (state == ST_DRAIN))
    else $error("last request did not start the drain");

  a_step_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ITER) |-> (step <= LAST_STEP))
    else $error("CORDIC step counter out of range");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> stat.out_free)
    else $error("result loaded while output register busy");

endmodule

`default_nettype wire

// File: hdl/nph_datapath.sv
// Distance pipeline, best-point registers, CORDIC and output register.
// Depends on nph_pkg; sequenced by nph_ctrl.
`default_nettype none

module nph_datapath
  import nph_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [COORD_W-1:0]   cfg_data,
  input  wire logic [COORD_W-1:0]   other_x,
  input  wire logic [COORD_W-1:0]   other_y,
  input  wire nph_cmd_t             cmd,
  output nph_stat_t                 stat,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic                      out_found,
  output logic [COORD_W-1:0]        out_x,
  output logic [COORD_W-1:0]        out_y,
  output logic                      out_turn,
  output logic signed [HEAD_W-1:0]  out_heading
);

  logic [COORD_W-1:0] self_x, self_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      self_x <= '0;
      self_y <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SELF_X: self_x <= cfg_data;
        REG_SELF_Y: self_y <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stage one: per-axis differences and squares.
  logic signed [DIFF_W-1:0]   ddx, ddy;
  logic signed [2*DIFF_W-1:0] pdx, pdy;
  logic [SQ_W-1:0]            sq_x, sq_y;
  logic [COORD_W-1:0]         s1_x, s1_y;
  logic                       s1_valid;

  always_comb begin
    ddx = signed'({1'b0, other_x}) - signed'({1'b0, self_x});
    ddy = signed'({1'b0, other_y}) - signed'({1'b0, self_y});
    pdx = ddx * ddx;
    pdy = ddy * ddy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= cmd.accept;
    end
    if (cmd.accept) begin
      sq_x <= pdx[SQ_W-1:0];
      sq_y <= pdy[SQ_W-1:0];
      s1_x <= other_x;
      s1_y <= other_y;
    end
  end

  // Stage two: sum and compare with the best so far; ties keep the earlier point.
  logic [DIST_W-1:0]  cur_dist, best_dist;
  logic [COORD_W-1:0] best_x, best_y;
  logic               have_best, take;

  always_comb begin
    cur_dist = {1'b0, sq_x} + {1'b0, sq_y};
    take = s1_valid && (cur_dist != '0) && (!have_best || (cur_dist < best_dist));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      have_best <= 1'b0;
    end else if (cmd.load_head) begin
      have_best <= 1'b0;
    end else if (take) begin
      have_best <= 1'b1;
    end
    if (take) begin
      best_dist <= cur_dist;
      best_x    <= s1_x;
      best_y    <= s1_y;
    end
  end

  // CORDIC in vectoring mode, one micro-rotation per cycle.
  logic signed [DIFF_W-1:0] hx, hy, ax, ay;
  logic                     hx_neg;
  logic                     res_found, res_turn;
  logic [COORD_W-1:0]       res_x, res_y;
  logic signed [XY_W-1:0]   cx, cy, xs, ys;
  logic signed [Z_W-1:0]    cz, ang;

  always_comb begin
    hx     = signed'({1'b0, best_x}) - signed'({1'b0, self_x});
    hy     = signed'({1'b0, best_y}) - signed'({1'b0, self_y});
    hx_neg = hx[DIFF_W-1];
    ax     = hx_neg ? -hx : hx;
    ay     = hx_neg ? -hy : hy;
    xs     = cx >>> cmd.step;
    ys     = cy >>> cmd.step;
    ang    = signed'({{(Z_W-ANG_TAB_W){1'b0}}, atan_q30(cmd.step)});
  end

  always_ff @(posedge clk) begin
    if (cmd.load_head) begin
      res_found <= have_best;
      res_turn  <= have_best && (hx != '0);
      res_x     <= have_best ? best_x : '0;
      res_y     <= have_best ? best_y : '0;
      cx <= {{(XY_W-DIFF_W-XY_FRAC){ax[DIFF_W-1]}}, ax, {XY_FRAC{1'b0}}};
      cy <= {{(XY_W-DIFF_W-XY_FRAC){ay[DIFF_W-1]}}, ay, {XY_FRAC{1'b0}}};
      if (!hx_neg) begin
        cz <= '0;
      end else if (!hy[DIFF_W-1]) begin
        cz <= PI_Q30;
      end else begin
        cz <= -PI_Q30;
      end
    end else if (cmd.iter) begin
      if (!cy[XY_W-1]) begin
        cx <= cx + ys;
        cy <= cy - xs;
        cz <= cz + ang;
      end else begin
        cx <= cx - ys;
        cy <= cy + xs;
        cz <= cz - ang;
      end
    end
  end

  // Heading is the negated angle, rounded to 13 fraction bits and clamped.
  logic signed [Z_W:0]        hsum;
  logic signed [HQ_W-1:0]     hq;
  logic signed [HEAD_W-1:0]   head_sat;

  always_comb begin
    hsum = ROUND_HALF - signed'({cz[Z_W-1], cz});
    hq   = hsum[Z_W:HEAD_SHIFT];
    if (hq > HEAD_MAX) begin
      head_sat = HEAD_W'(HEAD_MAX);
    end else if (hq < HEAD_MIN) begin
      head_sat = HEAD_W'(HEAD_MIN);
    end else begin
      head_sat = HEAD_W'(hq);
    end
  end

  always_comb begin
    stat.out_free = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (cmd.out_load) begin
      out_found   <= res_found;
      out_x       <= res_x;
      out_y       <= res_y;
      out_turn    <= res_turn;
      out_heading <= res_turn ? head_sat : '0;
    end
  end

  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_found) |->
      (!out_turn && (out_x == '0) && (out_y == '0) && (out_heading == '0)))
    else $error("result without a neighbor carries data");

  a_head_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((out_heading <= 16'sd25736) && (out_heading >= -16'sd25736)))
    else $error("heading outside clamp range");

  a_search_cleared: assert property (@(posedge clk) disable iff (rst)
    cmd.load_head |=> !have_best)
    else $error("search state not cleared after result capture");

endmodule

`default_nettype wire

// File: test/testbench.sv
// Testbench for nearest_point_heading: streams populations of points, predicts each
// nearest-point result and its CORDIC heading, and checks every result field by field.
// Depends on nph_pkg and the nearest_point_heading RTL.
`timescale 1ns / 1ps

module testbench;
  import nph_pkg::*;

  localparam int CORDIC_STEPS = 16;
  // Own result path: drain, load, CORDIC steps, output fill, plus margin.
  localparam int SETTLE_CYCLES = CORDIC_STEPS + 8;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_POINTS = 116;
  localparam longint HALF_TURN_Q30 = 64'sd3373259426;
  localparam longint BEARING_LIMIT = 64'sd25736;
  localparam int COORD_TOP = (1 << COORD_W) - 1;

  typedef struct {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               last;
  } point_t;

  typedef struct {
    logic               found;
    logic [COORD_W-1:0] nx;
    logic [COORD_W-1:0] ny;
    logic               turn;
    logic signed [15:0] heading;
  } neighbor_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic                  s_tlast = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [OUT_USER_W-1:0] m_tuser;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_SELF_X;
  logic [COORD_W-1:0]    cfg_data = '0;

  nearest_point_heading #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Points waiting to be offered, and results the block still owes us.
  point_t    point_queue[$];
  neighbor_t owed_results[$];

  // Bookkeeping shared between the stimulus, the driver and the monitor.
  int pushed_cnt = 0;     // points handed to the driver
  int sent_cnt = 0;       // points placed on the request bus
  int taken_cnt = 0;      // points accepted by the block
  int results_seen = 0;
  int mismatches = 0;
  int positions_used = 1;
  int cycles = 0;
  bit gaps_on = 1'b1;     // random idle bursts on both sides
  int holds_asked = 0;    // long receiver hold-offs requested by the stimulus
  int holds_done = 0;

  // The predictor's own copy of the position registers and of the search state.
  logic [COORD_W-1:0] own_x;
  logic [COORD_W-1:0] own_y;
  longint             best_dsq;
  logic [COORD_W-1:0] best_px;
  logic [COORD_W-1:0] best_py;
  bit                 best_valid;

  // Stimulus side copy of the position, used to aim points near it.
  int aim_x = 0;
  int aim_y = 0;

  // atan(2^-i) in Q30 for the micro-rotations.
  function automatic longint rot_angle(input int i);
    case (i)
      0:  return 843314857;
      1:  return 497837829;
      2:  return 263043837;
      3:  return 133525159;
      4:  return 67021687;
      5:  return 33543516;
      6:  return 16775851;
      7:  return 8388437;
      8:  return 4194283;
      9:  return 2097149;
      10: return 1048576;
      11: return 524288;
      12: return 262144;
      13: return 131072;
      14: return 65536;
      15: return 32768;
      16: return 16384;
      17: return 8192;
      18: return 4096;
      19: return 2048;
      20: return 1024;
      21: return 512;
      22: return 256;
      23: return 128;
      default: return 0;
    endcase
  endfunction

  // Minus atan2(dy, dx) in Q13, by a vectoring CORDIC on the scaled offsets.
  function automatic logic signed [15:0] bearing_q13(input longint dx_in, input longint dy_in);
    longint dx, dy, x, y, z, xs, ys, h;
    dx = dx_in;
    dy = dy_in;
    z = 0;
    // Vectors pointing left are flipped into the right half plane first.
    if (dx < 0) begin
      z = (dy >= 0) ? HALF_TURN_Q30 : -HALF_TURN_Q30;
      dx = -dx;
      dy = -dy;
    end
    x = dx <<< 20;
    y = dy <<< 20;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        z = z + rot_angle(i);
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - rot_angle(i);
      end
    end
    h = (-z + 64'sd65536) >>> 17;
    if (h > BEARING_LIMIT) h = BEARING_LIMIT;
    if (h < -BEARING_LIMIT) h = -BEARING_LIMIT;
    return h[15:0];
  endfunction

  function automatic void clear_search();
    best_dsq = (64'd1 << 25) - 1;
    best_px = '0;
    best_py = '0;
    best_valid = 1'b0;
  endfunction

  // Folds one accepted point into the search; the last point yields a result.
  function automatic void absorb_point(input point_t p);
    longint dx, dy, dsq, hx, hy;
    neighbor_t r;
    dx = longint'(p.x) - longint'(own_x);
    dy = longint'(p.y) - longint'(own_y);
    dsq = dx * dx + dy * dy;
    // Points sitting on the own position never count; ties keep the earlier point.
    if (dsq != 0 && (!best_valid || dsq < best_dsq)) begin
      best_dsq = dsq;
      best_px = p.x;
      best_py = p.y;
      best_valid = 1'b1;
    end
    if (p.last) begin
      r.found = best_valid;
      r.nx = best_valid ? best_px : '0;
      r.ny = best_valid ? best_py : '0;
      r.turn = 1'b0;
      r.heading = '0;
      if (best_valid) begin
        hx = longint'(best_px) - longint'(own_x);
        hy = longint'(best_py) - longint'(own_y);
        // A neighbor straight above or below gives no new heading.
        if (hx != 0) begin
          r.turn = 1'b1;
          r.heading = bearing_q13(hx, hy);
        end
      end
      owed_results.push_back(r);
      clear_search();
    end
  endfunction

  function automatic void note_mismatch(input string what, input neighbor_t want,
                                        input neighbor_t got);
    mismatches++;
    if (mismatches <= 10)
      $display({"[%0t] %s: expected found=%0b x=%0d y=%0d turn=%0b heading=%0d, ",
                "got found=%0b x=%0d y=%0d turn=%0b heading=%0d"},
               $time, what, want.found, want.nx, want.ny, want.turn, want.heading,
               got.found, got.nx, got.ny, got.turn, got.heading);
  endfunction

  function automatic void check_result(input neighbor_t got);
    neighbor_t want;
    results_seen++;
    if (owed_results.size() == 0) begin
      want = '{1'b0, '0, '0, 1'b0, '0};
      note_mismatch("result with nothing outstanding", want, got);
    end else begin
      want = owed_results.pop_front();
      if (got.found !== want.found || got.nx !== want.nx || got.ny !== want.ny ||
          got.turn !== want.turn || got.heading !== want.heading)
        note_mismatch("result mismatch", want, got);
    end
  endfunction

  // Monitor: everything at the rising edge, so it sees the values that the block sampled.
  always @(posedge clk) begin
    point_t    p;
    neighbor_t got;
    if (rst) begin
      own_x = '0;
      own_y = '0;
      clear_search();
    end else begin
      if (s_tvalid && s_tready) begin
        p.x = s_tdata[COORD_W-1:0];
        p.y = s_tdata[2*COORD_W-1:COORD_W];
        p.last = s_tlast;
        absorb_point(p);
        taken_cnt <= taken_cnt + 1;
      end
      if (cfg_we) begin
        if (cfg_index == REG_SELF_X) own_x = cfg_data;
        else if (cfg_index == REG_SELF_Y) own_y = cfg_data;
      end
      if (m_tvalid && m_tready) begin
        got.found = m_tuser[0];
        got.turn = m_tuser[1];
        got.nx = m_tdata[COORD_W-1:0];
        got.ny = m_tdata[2*COORD_W-1:COORD_W];
        got.heading = m_tdata[2*COORD_W+15:2*COORD_W];
        check_result(got);
      end
    end
  end

  // Request driver: holds a point until it is taken, then idles or offers the next one.
  int send_gap = 0;
  always @(negedge clk) begin
    point_t p;
    if (!rst && taken_cnt == sent_cnt) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        s_tvalid <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 7) == 0) begin
        send_gap <= $urandom_range(0, 17);
        s_tvalid <= 1'b0;
      end else if (point_queue.size() != 0) begin
        p = point_queue.pop_front();
        s_tvalid <= 1'b1;
        s_tdata <= {p.y, p.x};
        s_tlast <= p.last;
        sent_cnt <= sent_cnt + 1;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Result receiver: random stalls, plus long hold-offs on request so the block backs up.
  int recv_gap = 0;
  int hold_left = 0;
  always @(negedge clk) begin
    if (!rst) begin
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        m_tready <= 1'b0;
      end else if (holds_done != holds_asked) begin
        hold_left <= HOLD_CYCLES - 1;
        holds_done <= holds_done + 1;
        m_tready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        m_tready <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
        recv_gap <= $urandom_range(0, 17);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("nearest_point_heading test failed");
      $finish;
    end
  end

  function automatic logic [COORD_W-1:0] to_coord(input int v);
    if (v < 0) return '0;
    if (v > COORD_TOP) return COORD_W'(COORD_TOP);
    return COORD_W'(v);
  endfunction

  function automatic bit on_grid(input int x, input int y);
    return x >= 0 && x <= COORD_TOP && y >= 0 && y <= COORD_TOP;
  endfunction

  task automatic add_point(input int x, input int y, input bit last);
    point_t p;
    p.x = COORD_W'(x);
    p.y = COORD_W'(y);
    p.last = last;
    point_queue.push_back(p);
    pushed_cnt++;
  endtask

  // One random population. Besides uniform points it aims points close to the own
  // position, right on it (skipped by the block) and at equal distance to an earlier one.
  task automatic add_population(input int len);
    int kind, x, y, px, py, ox, oy;
    px = 0;
    py = 0;
    for (int k = 0; k < len; k++) begin
      kind = $urandom_range(0, 9);
      x = $urandom_range(0, COORD_TOP);
      y = $urandom_range(0, COORD_TOP);
      if (kind == 6 || kind == 7) begin
        x = to_coord(aim_x + $urandom_range(0, 8) - 4);
        y = to_coord(aim_y + $urandom_range(0, 8) - 4);
      end else if (kind == 8) begin
        x = aim_x;
        y = aim_y;
      end else if (kind == 9 && k > 0) begin
        // Same distance as the previous point: mirror its offset.
        ox = px - aim_x;
        oy = py - aim_y;
        if (on_grid(aim_x + oy, aim_y + ox)) begin
          x = aim_x + oy;
          y = aim_y + ox;
        end else if (on_grid(aim_x - ox, aim_y - oy)) begin
          x = aim_x - ox;
          y = aim_y - oy;
        end else begin
          x = px;
          y = py;
        end
      end
      add_point(x, y, k == len - 1);
      px = x;
      py = y;
    end
  endtask

  task automatic write_position(input int x, input int y);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= REG_SELF_X;
    cfg_data <= COORD_W'(x);
    @(negedge clk);
    cfg_index <= REG_SELF_Y;
    cfg_data <= COORD_W'(y);
    @(negedge clk);
    cfg_we <= 1'b0;
    aim_x = x;
    aim_y = y;
    positions_used++;
  endtask

  // Waits until every point is taken and every result is back, then lets the
  // block settle before the position registers are touched.
  task automatic drain();
    while (taken_cnt != pushed_cnt || owed_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int sx, sy, len, phase_start;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part, own position still at its reset value of zero.
    add_point(0, 0, 1);                 // empty population: only a point on ourselves
    add_point(COORD_TOP, COORD_TOP, 0);
    add_point(0, 0, 1);
    add_point(5, 0, 0);                 // three points at the same distance, first wins
    add_point(0, 5, 0);
    add_point(3, 4, 1);
    add_point(0, COORD_TOP, 1);         // straight above: no heading
    drain();

    // Own position in the far corner: vectors to the lower left.
    write_position(COORD_TOP, COORD_TOP);
    add_point(0, 0, 1);
    add_point(0, COORD_TOP, 1);         // straight left, angle at the half turn
    add_point(COORD_TOP, 0, 1);
    drain();

    write_position(2048, 2048);
    add_point(2048, 2048, 0);
    add_point(1000, 3000, 0);
    add_point(3000, 1000, 1);           // tie across quadrants
    add_point(2049, 2047, 1);
    add_point(2047, 2049, 1);
    add_point(2047, 2047, 0);
    add_point(2049, 2049, 1);
    add_point(2048, 2048, 0);           // two points on ourselves: not found
    add_point(2048, 2048, 1);
    add_point(COORD_TOP, 2048, 1);
    add_point(0, 2048, 1);
    drain();

    // Random part, one own position per phase.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin sx = 0; sy = COORD_TOP; end
        2: begin sx = COORD_TOP; sy = 0; end
        4: begin sx = 0; sy = 0; end
        6: begin sx = COORD_TOP; sy = COORD_TOP; end
        default: begin
          sx = $urandom_range(0, COORD_TOP);
          sy = $urandom_range(0, COORD_TOP);
        end
      endcase
      write_position(sx, sy);
      // One stretch without idling mid-run, and none at all at the end.
      gaps_on = (ph != 5 && ph != 7);
      // Short populations behind a long receiver hold-off fill the block up.
      if (ph == 3) holds_asked++;
      phase_start = pushed_cnt;
      while (pushed_cnt - phase_start < PHASE_POINTS) begin
        if (ph == 3) len = $urandom_range(1, 2);
        else if ($urandom_range(0, 9) == 0) len = $urandom_range(11, 30);
        else len = $urandom_range(1, 10);
        add_population(len);
      end
      drain();
    end

    $display("Covered %0d points over %0d own positions, including empty and tied populations.",
             taken_cnt, positions_used);
    $display("Compared %0d results, %0d mismatches.", results_seen, mismatches);
    if (mismatches == 0 && owed_results.size() == 0)
      $display("nearest_point_heading test passed");
    else
      $display("nearest_point_heading test failed");
    $finish;
  end

endmodule
